// ----- design/brf_pkg.sv -----
// Shared widths, reset values, opcodes and register indexes for the byte ring FIFO.
// No dependencies; used by the top level and the port checker.
package brf_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int FRAME_DEF  = 32;

    localparam int OP_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int AMT_W      = 11;
    localparam int OFF_W      = 10;
    localparam int TIME_W     = 32;
    localparam int CNT_OUT_W  = 11;
    localparam int THR_W      = 11;
    localparam int TMO_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam op_t OP_PUSH   = 3'd0;
    localparam op_t OP_ROOM   = 3'd1;
    localparam op_t OP_POP    = 3'd2;
    localparam op_t OP_PEEK   = 3'd3;
    localparam op_t OP_COMMIT = 3'd4;
    localparam op_t OP_QUERY  = 3'd5;

    localparam cfg_idx_t REG_THRESHOLD = 2'd0;
    localparam cfg_idx_t REG_TIMEOUT   = 2'd1;

    localparam logic [THR_W-1:0] THR_RESET = 11'd256;
    localparam logic [TMO_W-1:0] TMO_RESET = 16'd100;

endpackage

// ----- design/byte_ring_fifo_with_notify_top.sv -----
// Byte ring FIFO with consumer notify flag: sequencer, ring store and output register.
// Depends on brf_pkg.
//
// One request is taken at a time. Push, pop, peek, commit/drop and query pass through
// accept, execute with the single ring store access, and result load, and the block takes
// no new request until the result is loaded. Make room adds a drop step for each
// frame-sized chunk, since the single ring address adder retires one chunk per cycle,
// and one more step that finds a frame fits. The next request is taken while a result
// still waits in the output register; its own result cycle then stalls until the
// receiver takes the waiting one.
// The store needs no clearing after reset: only written bytes are ever read.
module byte_ring_fifo_with_notify_top #(
    parameter int DEPTH       = brf_pkg::DEPTH_DEF,
    parameter int FRAME_BYTES = brf_pkg::FRAME_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [brf_pkg::OP_W-1:0]       op,
    input  logic [brf_pkg::BYTE_W-1:0]     data_in,
    input  logic [brf_pkg::AMT_W-1:0]      amount,
    input  logic [brf_pkg::OFF_W-1:0]      offset,
    input  logic [brf_pkg::TIME_W-1:0]     now_time,
    input  logic [brf_pkg::TIME_W-1:0]     last_notify_time,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [brf_pkg::BYTE_W-1:0]     data_out,
    output logic                           ok,
    output logic [brf_pkg::CNT_OUT_W-1:0]  done_count,
    output logic [brf_pkg::CNT_OUT_W-1:0]  fill_count,
    output logic                           notify,
    input  logic                           cfg_we,
    input  logic [brf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import brf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > AMT_W) ? CW : AMT_W;
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [XW-1:0] FRAME_X = XW'(FRAME_BYTES);
    localparam logic [CW-1:0] FRAME_C = CW'(FRAME_BYTES);
    localparam bit            ROOM_OK = (FRAME_BYTES <= DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ROOM = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     done_reg, done_next;
    logic              ok_reg, ok_next;
    logic              rdsel_reg, rdsel_next;
    logic [THR_W-1:0]  thr_reg;
    logic [TMO_W-1:0]  tmo_reg;

    op_t               op_reg;
    logic [BYTE_W-1:0] din_reg;
    logic [AMT_W-1:0]  amount_reg;
    logic [OFF_W-1:0]  offset_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] last_reg;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [PW-1:0]     mem_raddr;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] data_out_reg;
    logic              ok_out_reg;
    logic [CNT_OUT_W-1:0] done_out_reg;
    logic [CNT_OUT_W-1:0] fill_out_reg;
    logic              notify_reg;
    logic              out_load;

    // shared ring address unit: base + step, folded back into the ring
    logic [PW-1:0]     ring_base;
    logic [CW-1:0]     ring_step;
    logic [CW:0]       ring_sum;
    logic [CW:0]       ring_wrap;
    logic [PW-1:0]     ring_res;

    logic [XW-1:0]     count_x, amount_x, offset_x, thr_x;
    logic [CW-1:0]     commit_k, chunk, free_c;
    logic              room_need, peek_hit;
    logic [TIME_W-1:0] elapsed;
    logic              notify_calc;
    logic [XW-1:0]     done_x, fill_x;

    assign count_x  = XW'(count_reg);
    assign amount_x = XW'(amount_reg);
    assign offset_x = XW'(offset_reg);
    assign thr_x    = XW'(thr_reg);

    assign commit_k  = (amount_x < count_x) ? CW'(amount_x) : count_reg;
    assign chunk     = (FRAME_X < count_x) ? FRAME_C : count_reg;
    assign free_c    = DEPTH_C - count_reg;
    assign room_need = ROOM_OK && (XW'(free_c) < FRAME_X);
    assign peek_hit  = offset_x < count_x;

    always_comb
    begin
        ring_base = head_reg;
        ring_step = '0;
        if (state_reg == S_ROOM)
        begin
            ring_step = chunk;
        end
        else
        begin
            case (op_reg)
                OP_PUSH:
                begin
                    ring_base = tail_reg;
                    ring_step = CW'(1);
                end
                OP_POP:    ring_step = CW'(1);
                OP_PEEK:   ring_step = CW'(offset_x);
                OP_COMMIT: ring_step = commit_k;
                default:   ring_step = '0;
            endcase
        end
    end

    assign ring_sum  = (CW + 1)'(ring_base) + (CW + 1)'(ring_step);
    assign ring_wrap = (ring_sum >= DEPTH_S) ? (ring_sum - DEPTH_S) : ring_sum;
    assign ring_res  = ring_wrap[PW-1:0];

    assign elapsed     = now_reg - last_reg;
    assign notify_calc = (count_x >= thr_x)
                      || ((count_x >= FRAME_X) && (elapsed >= TIME_W'(tmo_reg)));

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        done_next  = done_reg;
        ok_next    = ok_reg;
        rdsel_next = rdsel_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = head_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                    done_next  = '0;
                    ok_next    = 1'b0;
                    rdsel_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (count_reg < DEPTH_C)
                        begin
                            mem_we     = 1'b1;
                            tail_next  = ring_res;
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    OP_ROOM: state_next = S_ROOM;
                    OP_POP:
                    begin
                        if (count_reg != '0)
                        begin
                            mem_re     = 1'b1;
                            head_next  = ring_res;
                            count_next = count_reg - CW'(1);
                            ok_next    = 1'b1;
                            rdsel_next = 1'b1;
                        end
                    end
                    OP_PEEK:
                    begin
                        if (peek_hit)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = ring_res;
                            ok_next    = 1'b1;
                            rdsel_next = 1'b1;
                        end
                    end
                    OP_COMMIT:
                    begin
                        head_next  = ring_res;
                        count_next = count_reg - commit_k;
                        done_next  = commit_k;
                    end
                    default: ;  // query, and undefined codes act as query
                endcase
            end
            S_ROOM:
            begin
                // drop one frame-sized chunk per cycle until a frame fits
                if (room_need)
                begin
                    head_next  = ring_res;
                    count_next = count_reg - chunk;
                    done_next  = done_reg + chunk;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= '0;
            ok_reg        <= 1'b0;
            rdsel_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
            rdsel_reg <= rdsel_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            tmo_reg <= TMO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_wdata[THR_W-1:0];
                REG_TIMEOUT:   tmo_reg <= cfg_wdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg     <= op;
            din_reg    <= data_in;
            amount_reg <= amount;
            offset_reg <= offset;
            now_reg    <= now_time;
            last_reg   <= last_notify_time;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= din_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign done_x = XW'(done_reg);
    assign fill_x = XW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            data_out_reg <= rdsel_reg ? rd_data_reg : '0;
            ok_out_reg   <= ok_reg;
            done_out_reg <= done_x[CNT_OUT_W-1:0];
            fill_out_reg <= fill_x[CNT_OUT_W-1:0];
            notify_reg   <= notify_calc;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = data_out_reg;
    assign ok         = ok_out_reg;
    assign done_count = done_out_reg;
    assign fill_count = fill_out_reg;
    assign notify     = notify_reg;

endmodule

// ----- design/brf_checker.sv -----
// Port-level checks for the byte ring FIFO, bound to the top level.
// Depends on brf_pkg and byte_ring_fifo_with_notify_top.
module brf_checker #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [brf_pkg::BYTE_W-1:0]     data_out,
    input logic                           ok,
    input logic [brf_pkg::CNT_OUT_W-1:0]  done_count,
    input logic [brf_pkg::CNT_OUT_W-1:0]  fill_count
);
    import brf_pkg::*;

    // one request at a time: no new request right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in flight");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(fill_count) <= 32'(DEPTH)))
        else $error("fill count beyond store depth");

    // push/pop/peek success never reports dropped or committed bytes
    a_ok_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> done_count == '0)
        else $error("done count set on a successful byte access");

    a_data_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (data_out != '0) |-> ok)
        else $error("data out nonzero on a failed request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fill_count))
        else $error("result dropped or changed while stalled");

endmodule

bind byte_ring_fifo_with_notify_top brf_checker #(.DEPTH(DEPTH)) u_brf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_out   (data_out),
    .ok         (ok),
    .done_count (done_count),
    .fill_count (fill_count)
);

// ----- tb/sv/tb_byte_ring_fifo_with_notify_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_fifo_with_notify_top: a directed table, then random phases.
// Depends on brf_pkg and the top level; a ring mirror predicts responses the table does not fix.
module tb_byte_ring_fifo_with_notify_top;
    import brf_pkg::*;

    localparam int RING_DEPTH     = DEPTH_DEF;
    localparam int FRAME          = FRAME_DEF;
    localparam int HOLD_CYCLES    = 400;
    localparam int NUM_PHASES     = 5;
    localparam int PRESSURE_PHASE = 2;

    // codes the block treats as a query, and register slots it must ignore
    localparam op_t      OP_SPARE6  = 3'd6;
    localparam op_t      OP_SPARE7  = 3'd7;
    localparam cfg_idx_t REG_SPARE2 = 2'd2;
    localparam cfg_idx_t REG_SPARE3 = 2'd3;

    typedef struct packed {
        op_t                 op;
        logic [BYTE_W-1:0]   data;
        logic [AMT_W-1:0]    amount;
        logic [OFF_W-1:0]    offset;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   last;
    } fifo_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    data;
        logic                 ok;
        logic [CNT_OUT_W-1:0] done;
        logic [CNT_OUT_W-1:0] fill;
        logic                 notify;
    } fifo_res_t;

    typedef struct packed {
        fifo_req_t req;
        logic      typed_exp;
        fifo_res_t res;
    } plan_row_t;

    // per-phase settings: threshold, timeout, fill target, request count, idling
    int unsigned phase_thr   [NUM_PHASES] = '{256, 0, 16'hFFFF, 1024, 32};
    int unsigned phase_tmo   [NUM_PHASES] = '{100, 0, 16'hFFFF, 50, 1};
    int unsigned phase_target[NUM_PHASES] = '{40, 300, 1024, 1000, 0};
    int unsigned phase_items [NUM_PHASES] = '{120, 330, 900, 150, 150};
    int unsigned phase_gap   [NUM_PHASES] = '{0, 63, 0, 32, 0};
    int unsigned phase_stall [NUM_PHASES] = '{0, 0, 63, 32, 0};

    logic                  clk              = 1'b0;
    logic                  rst_n            = 1'b0;
    logic                  in_valid         = 1'b0;
    logic                  in_ready;
    op_t                   op               = OP_QUERY;
    logic [BYTE_W-1:0]     data_in          = '0;
    logic [AMT_W-1:0]      amount           = '0;
    logic [OFF_W-1:0]      offset           = '0;
    logic [TIME_W-1:0]     now_time         = '0;
    logic [TIME_W-1:0]     last_notify_time = '0;
    logic                  out_valid;
    logic                  out_ready        = 1'b0;
    logic [BYTE_W-1:0]     data_out;
    logic                  ok;
    logic [CNT_OUT_W-1:0]  done_count;
    logic [CNT_OUT_W-1:0]  fill_count;
    logic                  notify;
    logic                  cfg_we           = 1'b0;
    cfg_idx_t              cfg_index        = REG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_wdata        = '0;

    // ring mirror
    logic [BYTE_W-1:0] mirror_bytes [RING_DEPTH];
    int unsigned       mirror_head = 0;
    int unsigned       mirror_tail = 0;
    int unsigned       mirror_fill = 0;
    logic [THR_W-1:0]  mirror_thr  = THR_RESET;
    logic [TMO_W-1:0]  mirror_tmo  = TMO_RESET;

    fifo_res_t   pending_results[$];
    plan_row_t   plan[$];
    fifo_res_t   want_res;
    int unsigned fail_count       = 0;
    int unsigned sender_gap_pct   = 0;
    int unsigned receiver_stall_pct = 0;
    bit          hold_request     = 1'b0;
    bit          hold_taken       = 1'b0;
    int unsigned hold_left        = 0;

    byte_ring_fifo_with_notify_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .data_in          (data_in),
        .amount           (amount),
        .offset           (offset),
        .now_time         (now_time),
        .last_notify_time (last_notify_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .data_out         (data_out),
        .ok               (ok),
        .done_count       (done_count),
        .fill_count       (fill_count),
        .notify           (notify),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(5_000_000);
        $display("byte_ring_fifo_with_notify_top: mismatch");
        $finish;
    end

    // Apply one request to the mirror and return the response it should produce.
    function automatic fifo_res_t fifo_predict(input fifo_req_t r);
        fifo_res_t         res;
        int unsigned       chunk;
        logic [TIME_W-1:0] elapsed;
        res = '0;
        case (r.op)
            OP_PUSH:
            begin
                if (mirror_fill < RING_DEPTH)
                begin
                    mirror_bytes[mirror_tail] = r.data;
                    mirror_tail = (mirror_tail + 1) % RING_DEPTH;
                    mirror_fill++;
                    res.ok = 1'b1;
                end
            end
            OP_ROOM:
            begin
                // drop frame-sized chunks from the head until a frame fits
                if (FRAME <= RING_DEPTH)
                begin
                    while (RING_DEPTH - mirror_fill < FRAME)
                    begin
                        chunk = (mirror_fill < FRAME) ? mirror_fill : FRAME;
                        mirror_head = (mirror_head + chunk) % RING_DEPTH;
                        mirror_fill -= chunk;
                        res.done = res.done + CNT_OUT_W'(chunk);
                    end
                end
            end
            OP_POP:
            begin
                if (mirror_fill > 0)
                begin
                    res.data = mirror_bytes[mirror_head];
                    mirror_head = (mirror_head + 1) % RING_DEPTH;
                    mirror_fill--;
                    res.ok = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (r.offset < mirror_fill)
                begin
                    res.data = mirror_bytes[(mirror_head + r.offset) % RING_DEPTH];
                    res.ok = 1'b1;
                end
            end
            OP_COMMIT:
            begin
                chunk = (r.amount < mirror_fill) ? r.amount : mirror_fill;
                mirror_head = (mirror_head + chunk) % RING_DEPTH;
                mirror_fill -= chunk;
                res.done = CNT_OUT_W'(chunk);
            end
            default:
                ;
        endcase
        elapsed = r.now - r.last;
        res.fill = CNT_OUT_W'(mirror_fill);
        res.notify = (mirror_fill >= mirror_thr) ||
                     (mirror_fill >= FRAME && elapsed >= mirror_tmo);
        return res;
    endfunction

    // Random request steered toward a fill target: mostly pushes below it, any op above it.
    function automatic fifo_req_t random_request(input int unsigned target);
        fifo_req_t         r;
        logic [TIME_W-1:0] elapsed;
        r.data = BYTE_W'($urandom);
        if (mirror_fill < target && $urandom_range(0, 99) < 88)
            r.op = OP_PUSH;
        else
            r.op = op_t'($urandom_range(0, 7));
        if (mirror_fill < target)
            r.amount = AMT_W'($urandom_range(0, 3));
        else
        begin
            case ($urandom_range(0, 3))
                0: r.amount = AMT_W'($urandom_range(0, 2047));
                1: r.amount = AMT_W'($urandom_range(0, 64));
                2: r.amount = AMT_W'(mirror_fill + $urandom_range(0, 2) - 1);
                default: r.amount = $urandom_range(0, 1) ? '1 : AMT_W'(RING_DEPTH);
            endcase
        end
        if (mirror_fill > 0 && $urandom_range(0, 1))
            r.offset = OFF_W'($urandom_range(0, mirror_fill - 1));
        else
            r.offset = OFF_W'($urandom_range(0, 1023));
        r.now = $urandom;
        case ($urandom_range(0, 2))
            0: elapsed = TIME_W'(mirror_tmo) + TIME_W'($urandom_range(0, 2)) - 1;
            1: elapsed = TIME_W'($urandom_range(0, 200));
            default: elapsed = $urandom;
        endcase
        r.last = r.now - elapsed;
        return r;
    endfunction

    function automatic fifo_res_t outcome(input logic [BYTE_W-1:0] d, input int unsigned k,
                                          input int unsigned dn, input int unsigned fl,
                                          input int unsigned nt);
        fifo_res_t res;
        res.data   = d;
        res.ok     = 1'(k);
        res.done   = CNT_OUT_W'(dn);
        res.fill   = CNT_OUT_W'(fl);
        res.notify = 1'(nt);
        return res;
    endfunction

    function automatic void add_row(input op_t o, input logic [BYTE_W-1:0] d,
                                    input logic [AMT_W-1:0] a, input logic [OFF_W-1:0] f,
                                    input logic [TIME_W-1:0] t_now,
                                    input logic [TIME_W-1:0] t_last,
                                    input logic typed_exp, input fifo_res_t res);
        plan_row_t pr;
        pr.req.op     = o;
        pr.req.data   = d;
        pr.req.amount = a;
        pr.req.offset = f;
        pr.req.now    = t_now;
        pr.req.last   = t_last;
        pr.typed_exp  = typed_exp;
        pr.res        = res;
        plan.push_back(pr);
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_THRESHOLD)
            mirror_thr = val[THR_W-1:0];
        else if (idx == REG_TIMEOUT)
            mirror_tmo = val[TMO_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic offer(input fifo_req_t r, input logic typed_exp, input fifo_res_t typed_res);
        fifo_res_t predicted;
        if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < sender_gap_pct);
        end
        op               <= r.op;
        data_in          <= r.data;
        amount           <= r.amount;
        offset           <= r.offset;
        now_time         <= r.now;
        last_notify_time <= r.last;
        in_valid         <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = fifo_predict(r);
        pending_results.push_back(typed_exp ? typed_res : predicted);
        @(negedge clk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected response: expected none, got data %0h ok %b",
                         $time, data_out, ok);
                $display("%0t   done %0d fill %0d notify %b",
                         $time, done_count, fill_count, notify);
                fail_count++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                check_field("data_out", 32'(want_res.data), 32'(data_out));
                check_field("ok", 32'(want_res.ok), 32'(ok));
                check_field("done_count", 32'(want_res.done), 32'(done_count));
                check_field("fill_count", 32'(want_res.fill), 32'(fill_count));
                check_field("notify", 32'(want_res.notify), 32'(notify));
            end
        end
    end

    initial
    begin
        int unsigned n;
        // empty ring first: every failing op reports zeros
        add_row(OP_QUERY, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 0, 0, 0));
        add_row(OP_POP, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 0, 0, 0));
        add_row(OP_PEEK, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 0, 0, 0));
        add_row(OP_PEEK, 8'hFF, 11'h7FF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                outcome(8'h00, 0, 0, 0, 0));
        add_row(OP_COMMIT, 8'h00, 11'h7FF, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 0, 0, 0));
        add_row(OP_ROOM, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 0, 0, 0));
        add_row(OP_SPARE6, 8'hFF, 11'h7FF, 10'h3FF, 32'hFFFF_FFFF, 32'h0, 1'b1,
                outcome(8'h00, 0, 0, 0, 0));
        add_row(OP_SPARE7, 8'hFF, 11'h7FF, 10'h3FF, 32'h0, 32'hFFFF_FFFF, 1'b1,
                outcome(8'h00, 0, 0, 0, 0));
        add_row(OP_PUSH, 8'hFF, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 1, 0, 1, 0));
        add_row(OP_PUSH, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 1, 0, 2, 0));
        add_row(OP_PUSH, 8'h5A, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 1, 0, 3, 0));
        add_row(OP_PEEK, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b0, '0);
        add_row(OP_PEEK, 8'h00, 11'd0, 10'd2, 32'h0, 32'h0, 1'b0, '0);
        add_row(OP_PEEK, 8'h00, 11'd0, 10'd3, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 0, 3, 0));
        add_row(OP_POP, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b0, '0);
        add_row(OP_COMMIT, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 0, 2, 0));
        add_row(OP_PUSH, 8'hA5, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 1, 0, 3, 0));
        add_row(OP_ROOM, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 0, 3, 0));
        add_row(OP_COMMIT, 8'h00, 11'h7FF, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 3, 0, 0));
        add_row(OP_POP, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b1, outcome(8'h00, 0, 0, 0, 0));
        add_row(OP_PUSH, 8'h3C, 11'd0, 10'd0, 32'h0, 32'h0, 1'b0, '0);
        add_row(OP_POP, 8'h00, 11'd0, 10'd0, 32'h0, 32'h0, 1'b0, '0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
            offer(plan[i].req, plan[i].typed_exp, plan[i].res);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge clk);
            write_reg(REG_THRESHOLD, CFG_DATA_W'(phase_thr[ph]));
            write_reg(REG_TIMEOUT, CFG_DATA_W'(phase_tmo[ph]));
            // unmapped slots written last so a bad decode would clobber the real ones
            write_reg(REG_SPARE2, CFG_DATA_W'($urandom));
            write_reg(REG_SPARE3, CFG_DATA_W'($urandom));
            sender_gap_pct     = phase_gap[ph];
            receiver_stall_pct = phase_stall[ph];
            if (ph == PRESSURE_PHASE)
                hold_request = 1'b1;
            for (n = 0; n < phase_items[ph]; n++)
                offer(random_request(phase_target[ph]), 1'b0, '0);
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("byte_ring_fifo_with_notify_top: match");
        else
            $display("byte_ring_fifo_with_notify_top: mismatch");
        $finish;
    end

endmodule
